### rtl/core/bezier_path_flattener_macros.svh
// assertion macros for the bezier path flattener
// used by the top level only; no other dependencies
`ifndef BEZIER_PATH_FLATTENER_MACROS_SVH
`define BEZIER_PATH_FLATTENER_MACROS_SVH

`ifndef SYNTH
`define BPF_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bpf check failed");
`define BPF_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bpf check failed");
`else
`define BPF_ASSERT_IMP(label, clk, rst, pre, post)
`define BPF_ASSERT_NXT(label, clk, rst, pre, post)
`endif

`endif

### rtl/core/bpf_pkg.sv
// shared types and constants for the bezier path flattener
// no dependencies
package bpf_pkg;

  localparam int MAX_RESOLUTION = 65;
  localparam int COORD_W        = 32;
  localparam int RES_W          = 7;
  localparam int N_W            = 7;   // segment count n, 1..64
  localparam int SQ_W           = 13;  // n*n and a*a, up to 4096
  localparam int W_W            = 20;  // bernstein weights, below 2^19
  localparam int DEN_W          = 20;  // twice the denominator, up to 2^19
  localparam int NUM_W          = 56;  // biased dividend
  localparam int QUEUE_DEPTH    = 2;
  localparam int IN_DATA_W      = 6 * COORD_W;
  localparam int OUT_DATA_W     = 2 * COORD_W;

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(17);

  localparam logic [2:0] KIND_MOVE  = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_QUAD  = 3'd2;
  localparam logic [2:0] KIND_CUBIC = 3'd3;
  localparam logic [2:0] KIND_CLOSE = 3'd4;

  typedef enum logic [1:0] {
    OP_POINT,
    OP_CLOSE,
    OP_QUAD,
    OP_CUBIC
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [N_W-1:0]             n;
    logic signed [COORD_W-1:0]  ex;
    logic signed [COORD_W-1:0]  ey;
    logic signed [COORD_W-1:0]  c1x;
    logic signed [COORD_W-1:0]  c1y;
    logic signed [COORD_W-1:0]  c2x;
    logic signed [COORD_W-1:0]  c2y;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/bpf_front.sv
// front end: resolution register, request decode and classification
// depends on bpf_pkg
module bpf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpf_pkg::RES_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  logic [bpf_pkg::IN_DATA_W-1:0] in_data,
  input  bpf_pkg::q_stat_t              q_stat,
  output logic                          push,
  output bpf_pkg::cmd_t                 cmd
);
  import bpf_pkg::*;

  logic [RES_W-1:0] resolution;
  logic [RES_W-1:0] res_clamped;
  logic             known;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_RESET;
    end else if (cfg_we) begin
      resolution <= cfg_wdata;
    end
  end

  always_comb begin
    if (resolution < RES_W'(2)) begin
      res_clamped = RES_W'(2);
    end else if (resolution > RES_W'(MAX_RESOLUTION)) begin
      res_clamped = RES_W'(MAX_RESOLUTION);
    end else begin
      res_clamped = resolution;
    end
  end

  always_comb begin
    known  = 1'b1;
    cmd.op = OP_POINT;
    case (in_kind)
      KIND_MOVE:  cmd.op = OP_POINT;
      KIND_LINE:  cmd.op = OP_POINT;
      KIND_QUAD:  cmd.op = OP_QUAD;
      KIND_CUBIC: cmd.op = OP_CUBIC;
      KIND_CLOSE: cmd.op = OP_CLOSE;
      default:    known  = 1'b0;
    endcase
    cmd.n   = N_W'(res_clamped - RES_W'(1));
    cmd.ex  = in_data[0*COORD_W +: COORD_W];
    cmd.ey  = in_data[1*COORD_W +: COORD_W];
    cmd.c1x = in_data[2*COORD_W +: COORD_W];
    cmd.c1y = in_data[3*COORD_W +: COORD_W];
    cmd.c2x = in_data[4*COORD_W +: COORD_W];
    cmd.c2y = in_data[5*COORD_W +: COORD_W];
  end

  // unknown kinds are taken and dropped
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready && known;

endmodule

### rtl/core/bpf_queue.sv
// small command queue between front and back end
// depends on bpf_pkg
module bpf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bpf_pkg::cmd_t    wr_cmd,
  input  logic             pop,
  output bpf_pkg::cmd_t    rd_cmd,
  output bpf_pkg::q_stat_t stat
);
  import bpf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign rd_cmd     = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

### rtl/core/bpf_div.sv
// restoring divider, one quotient bit per cycle, 32-bit quotient
// depends on bpf_pkg
module bpf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bpf_pkg::NUM_W-1:0] dividend,
  input  logic [bpf_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [bpf_pkg::COORD_W-1:0] quot
);
  import bpf_pkg::*;

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic [DEN_W-1:0]   rem;
  logic [COORD_W-1:0] low;
  logic [DEN_W-1:0]   dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DEN_W:0]     trial;
  logic               fits;

  assign trial = {rem, low[COORD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(COORD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // high part of the dividend is always below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[COORD_W +: DEN_W];
      low <= dividend[COORD_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, dvs}) : DEN_W'(trial);
      low  <= {low[COORD_W-2:0], 1'b0};
      quot <= {quot[COORD_W-2:0], fits};
    end
  end

endmodule

### rtl/core/bpf_back.sv
// back end: path state, bernstein weight and sample sequencer, output register
// depends on bpf_pkg and bpf_div
module bpf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  bpf_pkg::cmd_t                  cmd,
  input  bpf_pkg::q_stat_t               q_stat,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpf_pkg::OUT_DATA_W-1:0] out_data,
  output logic                           out_last
);
  import bpf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DEN,
    S_WEIGHT_A,
    S_WEIGHT_B,
    S_MAC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t state;
  cmd_t   cur;

  logic signed [COORD_W-1:0] cur_x, cur_y, first_x, first_y, p0_x, p0_y;
  logic                      have_point;

  logic [N_W-1:0]   idx;
  logic [SQ_W-1:0]  nsq, a2, b2, ab;
  logic [DEN_W-2:0] den;
  logic [W_W-1:0]   w0, w1, w2, w3;
  logic [1:0]       term;
  logic signed [NUM_W-1:0] acc_x, acc_y;

  logic [N_W-1:0]   a;
  logic             out_free;
  logic             load_out;
  logic [W_W-1:0]   w_sel;
  logic signed [COORD_W-1:0] cx_sel, cy_sel;
  logic signed [COORD_W+W_W:0] prod_x, prod_y;
  logic [NUM_W-1:0] dvd_x, dvd_y;
  logic [DEN_W-1:0] dvs;
  logic             div_go;
  logic             done_x, done_y;
  logic [COORD_W-1:0] q_x, q_y;

  assign a        = cur.n - idx;
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign div_go   = (state == S_DIV_GO);

  // a new vertex enters the output register this cycle
  assign load_out = out_free &&
                    (((state == S_SETUP) &&
                      ((cur.op == OP_POINT) || ((cur.op == OP_CLOSE) && have_point))) ||
                     (state == S_EMIT));

  always_comb begin
    case (term)
      2'd0: begin
        w_sel = w0; cx_sel = p0_x; cy_sel = p0_y;
      end
      2'd1: begin
        w_sel = w1; cx_sel = cur.c1x; cy_sel = cur.c1y;
      end
      2'd2: begin
        w_sel  = w2;
        cx_sel = (cur.op == OP_CUBIC) ? cur.c2x : cur.ex;
        cy_sel = (cur.op == OP_CUBIC) ? cur.c2y : cur.ey;
      end
      default: begin
        w_sel = w3; cx_sel = cur.ex; cy_sel = cur.ey;
      end
    endcase
  end

  assign prod_x = $signed({1'b0, w_sel}) * cx_sel;
  assign prod_y = $signed({1'b0, w_sel}) * cy_sel;

  // floor((2*num + den) / (2*den)) biased by 2^31 so the division is unsigned
  assign dvs   = {den, 1'b0};
  assign dvd_x = NUM_W'((acc_x <<< 1) + $signed(NUM_W'(den))
                        + $signed(NUM_W'(den) << COORD_W));
  assign dvd_y = NUM_W'((acc_y <<< 1) + $signed(NUM_W'(den))
                        + $signed(NUM_W'(den) << COORD_W));

  bpf_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dvd_x),
    .divisor  (dvs),
    .done     (done_x),
    .quot     (q_x)
  );

  bpf_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dvd_y),
    .divisor  (dvs),
    .done     (done_y),
    .quot     (q_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      first_x    <= '0;
      first_y    <= '0;
      have_point <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cur   <= cmd;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          case (cur.op)
            OP_POINT: begin
              if (out_free) begin
                out_data  <= {cur.ey, cur.ex};
                out_last  <= 1'b1;
                cur_x     <= cur.ex;
                cur_y     <= cur.ey;
                if (!have_point) begin
                  first_x    <= cur.ex;
                  first_y    <= cur.ey;
                  have_point <= 1'b1;
                end
                state <= S_IDLE;
              end
            end
            OP_CLOSE: begin
              if (!have_point) begin
                state <= S_IDLE;
              end else if (out_free) begin
                out_data  <= {first_y, first_x};
                out_last  <= 1'b1;
                cur_x     <= first_x;
                cur_y     <= first_y;
                state     <= S_IDLE;
              end
            end
            default: begin
              p0_x  <= cur_x;
              p0_y  <= cur_y;
              nsq   <= SQ_W'(cur.n * cur.n);
              idx   <= N_W'(1);
              state <= S_DEN;
            end
          endcase
        end
        S_DEN: begin
          den   <= (cur.op == OP_CUBIC) ? (DEN_W-1)'(nsq * cur.n) : (DEN_W-1)'(nsq);
          state <= S_WEIGHT_A;
        end
        S_WEIGHT_A: begin
          a2    <= SQ_W'(a * a);
          b2    <= SQ_W'(idx * idx);
          ab    <= SQ_W'(a * idx);
          state <= S_WEIGHT_B;
        end
        S_WEIGHT_B: begin
          if (cur.op == OP_CUBIC) begin
            w0 <= W_W'(a2 * a);
            w1 <= W_W'(a2 * idx * 2'd3);
            w2 <= W_W'(ab * idx * 2'd3);
            w3 <= W_W'(b2 * idx);
          end else begin
            w0 <= W_W'(a2);
            w1 <= W_W'({ab, 1'b0});
            w2 <= W_W'(b2);
            w3 <= '0;
          end
          term  <= 2'd0;
          acc_x <= '0;
          acc_y <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          acc_x <= acc_x + NUM_W'(prod_x);
          acc_y <= acc_y + NUM_W'(prod_y);
          term  <= term + 2'd1;
          if (term == 2'd3) begin
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          // both dividers run in lockstep
          if (done_x && done_y) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data  <= {~q_y[COORD_W-1], q_y[COORD_W-2:0],
                          ~q_x[COORD_W-1], q_x[COORD_W-2:0]};
            out_last  <= (idx == cur.n);
            cur_x     <= {~q_x[COORD_W-1], q_x[COORD_W-2:0]};
            cur_y     <= {~q_y[COORD_W-1], q_y[COORD_W-2:0]};
            if (!have_point) begin
              first_x    <= {~q_x[COORD_W-1], q_x[COORD_W-2:0]};
              first_y    <= {~q_y[COORD_W-1], q_y[COORD_W-2:0]};
              have_point <= 1'b1;
            end
            if (idx == cur.n) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + N_W'(1);
              state <= S_WEIGHT_A;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/bezier_path_flattener.sv
// top level of the bezier path flattener: path command stream in, vertex stream out
// depends on bpf_pkg, bpf_front, bpf_queue, bpf_back and the assertion macro header
//
// s_axis carries one path command per request: tuser is the kind (move, line,
// quadratic, cubic, close), tdata the end point and control points. m_axis
// carries one vertex per request, tlast marks the final vertex of a command.
// cfg_we/cfg_wdata write the curve resolution R (reset 17, clamped to 2..65).
// A two-entry command queue decouples input decode from vertex generation,
// so up to two commands are taken while the back end is busy or stalled.
// Move, line and close pass through the queue to the output register; a close
// shows only once a point exists. A curve emits R-1 vertices; each one takes the
// weight and four-term multiply-accumulate steps, then the 32-step restoring
// dividers that round the weighted sum (x and y in parallel).
// Reset clears the queue, the current and first point and the output
// valid flag; the resolution returns to 17. When m_axis stalls the vertex
// holds in its output register and the sequencer waits; the queue then
// fills and s_axis_tready drops.
module bezier_path_flattener (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bpf_pkg::RES_W-1:0]      cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
  input  logic [bpf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [2:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_x, out_y
  output logic [bpf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);
  import bpf_pkg::*;

  cmd_t    front_cmd;
  cmd_t    back_cmd;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  bpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (front_cmd)
  );

  bpf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .rd_cmd (back_cmd),
    .stat   (q_stat)
  );

  bpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

`include "bezier_path_flattener_macros.svh"

  `BPF_ASSERT_IMP(a_push_not_full, clk, rst, push, !q_stat.full)
  `BPF_ASSERT_IMP(a_pop_not_empty, clk, rst, pop, !q_stat.empty)
  `BPF_ASSERT_NXT(a_full_holds, clk, rst, q_stat.full && !pop, q_stat.full)

endmodule
